### rtl/core/u8sd_pkg.sv
`default_nettype none

package u8sd_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [15:0] code_point;
      logic        status;
   } rsp_type;

   // what the decoder tells the pipeline control about the current item
   typedef struct packed {
      logic emit;
      logic idle;
   } dec_status_type;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   localparam logic [7:0] ASCII_LIMIT  = 8'h80;
   localparam logic [7:0] LEAD2_MASK   = 8'hE0;
   localparam logic [7:0] LEAD2_CODE   = 8'hC0;
   localparam logic [7:0] LEAD3_MASK   = 8'hF0;
   localparam logic [7:0] LEAD3_CODE   = 8'hE0;
   localparam logic [7:0] CONT_MASK    = 8'hC0;
   localparam logic [7:0] CONT_CODE    = 8'h80;
   localparam logic [7:0] CONT_PAYLOAD = 8'h3F;
   localparam logic [7:0] LEAD2_PAYLOAD = 8'h1F;
   localparam logic [7:0] LEAD3_PAYLOAD = 8'h0F;

endpackage

`default_nettype wire

### rtl/core/u8sd_decode.sv
`default_nettype none

module u8sd_decode
   import u8sd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire req_type        item,
   output dec_status_type      dec_status,
   output rsp_type             result
);

   logic [1:0] bytes_remaining_ff, bytes_remaining_in;
   logic [9:0] partial_value_ff, partial_value_in;
   logic       sequence_bad_ff, sequence_bad_in;

   logic        emit;
   logic [15:0] cp;
   logic        bad;
   logic [1:0]  rem_dec;

   always_comb begin
      bytes_remaining_in = bytes_remaining_ff;
      partial_value_in   = partial_value_ff;
      sequence_bad_in    = sequence_bad_ff;
      emit               = 1'b0;
      result.code_point  = 16'h0000;
      result.status      = STATUS_BAD;
      bad                = sequence_bad_ff | ((item.in_byte & CONT_MASK) != CONT_CODE);
      cp                 = {partial_value_ff, item.in_byte[5:0] & CONT_PAYLOAD[5:0]};
      rem_dec            = bytes_remaining_ff - 2'd1;

      if (bytes_remaining_ff == 2'd0) begin
         if (item.in_byte < ASCII_LIMIT) begin
            emit              = 1'b1;
            result.code_point = {8'h00, item.in_byte};
            result.status     = STATUS_OK;
         end else if ((item.in_byte & LEAD2_MASK) == LEAD2_CODE) begin
            if (item.end_of_buffer) begin
               emit = 1'b1;
            end else begin
               bytes_remaining_in = 2'd1;
               partial_value_in   = {2'b00, item.in_byte & LEAD2_PAYLOAD};
               sequence_bad_in    = 1'b0;
            end
         end else if ((item.in_byte & LEAD3_MASK) == LEAD3_CODE) begin
            if (item.end_of_buffer) begin
               emit = 1'b1;
            end else begin
               bytes_remaining_in = 2'd2;
               partial_value_in   = {2'b00, item.in_byte & LEAD3_PAYLOAD};
               sequence_bad_in    = 1'b0;
            end
         end else begin
            // four-byte lead, stray continuation or invalid lead byte
            emit = 1'b1;
         end
      end else begin
         if (rem_dec == 2'd0) begin
            emit               = 1'b1;
            result.code_point  = bad ? 16'h0000 : cp;
            result.status      = bad ? STATUS_BAD : STATUS_OK;
            bytes_remaining_in = 2'd0;
            partial_value_in   = 10'd0;
            sequence_bad_in    = 1'b0;
         end else if (item.end_of_buffer) begin
            // cut short by end of buffer
            emit               = 1'b1;
            bytes_remaining_in = 2'd0;
            partial_value_in   = 10'd0;
            sequence_bad_in    = 1'b0;
         end else begin
            bytes_remaining_in = rem_dec;
            partial_value_in   = cp[9:0];
            sequence_bad_in    = bad;
         end
      end
   end

   assign dec_status = '{emit: emit, idle: (bytes_remaining_ff == 2'd0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_remaining_ff <= 2'd0;
         partial_value_ff   <= 10'd0;
         sequence_bad_ff    <= 1'b0;
      end else if (step) begin
         bytes_remaining_ff <= bytes_remaining_in;
         partial_value_ff   <= partial_value_in;
         sequence_bad_ff    <= sequence_bad_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/utf8_stream_decoder_top.sv
`default_nettype none

// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_item : req_type (in_byte, end_of_buffer)
// rsp       out        rsp_valid / rsp_stall   rsp_item : rsp_type (code_point, status)
//
// one byte per cycle sustained while rsp_stall is low; a byte's result is loaded into the
// result register when the byte leaves the input register (input register, then decode
// into the result register); a byte produces zero or one result; the decode state advances
// when the byte leaves the input register
// reset is synchronous and empties both registers and returns the decoder to idle
// rsp_stall holds the result register and, through it, the input register; req_stall
// rises only while the input register holds a byte that cannot move on

module utf8_stream_decoder_top
   import u8sd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_item
);

   logic           in_vld_ff;
   req_type        in_item_ff;
   logic           out_vld_ff, out_vld_in;
   rsp_type        out_item_ff;
   logic           out_free;
   logic           advance;
   logic           req_take;
   dec_status_type dec_status;
   rsp_type        dec_result;

   u8sd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_item_ff),
      .dec_status (dec_status),
      .result     (dec_result)
   );

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign out_vld_in = advance ? dec_status.emit : (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_take || advance) begin
            in_vld_ff <= req_take;
         end
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance && dec_status.emit) begin
         out_item_ff <= dec_result;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_item_ff;

   // invalid results always carry a zero code point
   a_bad_is_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == STATUS_BAD |-> rsp_item.code_point == 16'h0000)
      else $error("invalid result with nonzero code point");

   // an ascii byte seen while idle comes straight out as a valid result
   a_ascii_pass : assert property (@(posedge clock) disable iff (reset)
      advance && dec_status.idle && in_item_ff.in_byte < ASCII_LIMIT |=>
         rsp_valid && rsp_item.status == STATUS_OK
         && rsp_item.code_point == {8'h00, $past(in_item_ff.in_byte)})
      else $error("ascii byte not passed through");

   // a decoded result is never dropped on the way to the result register
   a_emit_lands : assert property (@(posedge clock) disable iff (reset)
      advance && dec_status.emit |=> rsp_valid)
      else $error("decoded result lost");

   // the decoder never stays mid-sequence on a byte that ends a buffer
   a_eob_idle : assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.end_of_buffer |=> dec_status.idle)
      else $error("decoder not idle after end of buffer");

endmodule

`default_nettype wire
